// File: hdl/qlr_pkg.sv
// Package: constants, types and saturating helpers for the Q-learning rate controller.
package qlr_pkg;

  localparam int NUM_BINS  = 10;
  localparam int NUM_MOVES = 3;
  localparam int Q_BITS    = 40;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int ENTRIES   = NUM_BINS * NUM_MOVES;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int FRAC      = 16;
  localparam int PROD_W    = Q_BITS + FRAC;
  localparam int DVD_W     = 41;
  localparam int DVS_W     = 33;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam logic [31:0] EPS_Q824 = 32'd168;
  // (2^34 + 1) / 5: floor(x * RATE_RECIP / 2^34) == floor(x / 5) for any 32-bit x
  localparam logic [31:0] RATE_RECIP = 32'hCCCC_CCCD;

  localparam logic [1:0] ACT_DEC  = 2'd0;
  localparam logic [1:0] ACT_HOLD = 2'd1;
  localparam logic [1:0] ACT_INC  = 2'd2;
  localparam logic [1:0] ACT_BAD  = 2'd3;

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_GAMMA   = 3'd1;
  localparam logic [2:0] REG_EXPLORE = 3'd2;
  localparam logic [2:0] REG_LR_INIT = 3'd3;
  localparam logic [2:0] REG_LR_MIN  = 3'd4;
  localparam logic [2:0] REG_LR_MAX  = 3'd5;

  typedef logic signed [Q_BITS-1:0] q_t;

  localparam q_t Q_HI = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam q_t Q_LO = {1'b1, {(Q_BITS-1){1'b0}}};

  typedef struct packed {
    logic acc;
    logic div_start;
    logic rate_mul;
    logic rd_run;
    logic best;
    logic mul1;
    logic tgt;
    logic td;
    logic mul2;
    logic wr;
    logic arg;
    logic fin;
  } qlr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rd_done;
    logic out_busy;
  } qlr_sts_t;

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [Q_BITS:0] s;
    s = {a[Q_BITS-1], a} + {b[Q_BITS-1], b};
    if (s[Q_BITS] != s[Q_BITS-1]) return s[Q_BITS] ? Q_LO : Q_HI;
    return s[Q_BITS-1:0];
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [Q_BITS:0] s;
    s = {a[Q_BITS-1], a} - {b[Q_BITS-1], b};
    if (s[Q_BITS] != s[Q_BITS-1]) return s[Q_BITS] ? Q_LO : Q_HI;
    return s[Q_BITS-1:0];
  endfunction

  function automatic logic [Q_BITS-1:0] q_mag(input q_t v);
    return v[Q_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: hdl/qlr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module qlr_div import qlr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic [DVD_W-1:0] dvd_r, dvd_nxt, quot_r, quot_nxt;
  logic [DVS_W-1:0] dvs_r, rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W:0]   sh;
  logic             ge;

  assign sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt  = ge ? DVS_W'(sh - {1'b0, dvs_r}) : sh[DVS_W-1:0];
      quot_nxt = {quot_r[DVD_W-2:0], ge};
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: hdl/qlr_datapath.sv
// Datapath: registers, Q table, multiply/saturate, action choice and rate scaling.
module qlr_datapath import qlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  qlr_cmd_t    cmd,
  output qlr_sts_t    sts,
  input  logic [31:0] in_loss_value,
  input  logic [15:0] in_explore_draw,
  input  logic [1:0]  in_random_action,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_learning_rate,
  output logic [1:0]  out_chosen_action,
  output logic [5:0]  out_loss_bin
);

  logic [15:0] alpha_r, gamma_r, explore_r;
  logic [31:0] lr_init_r, lr_min_r, lr_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= 16'd6554;
      gamma_r   <= 16'd58982;
      explore_r <= 16'd6554;
      lr_init_r <= 32'd268435;
      lr_min_r  <= 32'd2684;
      lr_max_r  <= 32'd268435456;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALPHA:   alpha_r   <= cfg_data[15:0];
        REG_GAMMA:   gamma_r   <= cfg_data[15:0];
        REG_EXPLORE: explore_r <= cfg_data[15:0];
        REG_LR_INIT: lr_init_r <= cfg_data;
        REG_LR_MIN:  lr_min_r  <= cfg_data;
        REG_LR_MAX:  lr_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // beat capture and bin
  logic [15:0]      draw_r;
  logic [1:0]       rnd_r;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [36:0]      loss20;

  assign loss20 = {1'b0, in_loss_value, 4'b0} + {3'b0, in_loss_value, 2'b0};
  assign bin_nxt = (loss20[36:24] >= 13'(NUM_BINS)) ? BIN_W'(NUM_BINS-1)
                                                   : loss20[BIN_W+23:24];

  logic [31:0]      rate_r;
  logic             loaded_r;
  logic [31:0]      steps_r;
  logic [BIN_W-1:0] pbin_r;
  logic [1:0]       pact_r;

  // reward divider
  logic             div_done;
  logic [DVD_W-1:0] div_quot, div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [1:0]       act_r;

  assign div_dvd = {1'b1, {(DVD_W-1){1'b0}}};
  assign div_dvs = DVS_W'({1'b0, in_loss_value} + {1'b0, EPS_Q824});

  qlr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Q table with per-entry valid bits
  q_t               mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  q_t               rd_q_r, rd_data, new_q;
  logic             rd_v_r;
  logic [2:0]       rd_cnt_r;

  assign wr_addr = ADDR_W'(pbin_r * NUM_MOVES) + ADDR_W'(pact_r);
  assign rd_addr = (rd_cnt_r == 3'd3) ? wr_addr
                 : ADDR_W'(bin_r * NUM_MOVES) + ADDR_W'(rd_cnt_r[1:0]);

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
    if (cmd.wr) mem[wr_addr] <= new_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (cmd.wr) vld_r[wr_addr] <= 1'b1;
    rd_v_r <= vld_r[rd_addr];
  end

  assign rd_data = rd_v_r ? rd_q_r : '0;

  q_t qb_r [NUM_MOVES];
  q_t cur_r, best_r, tgt_r, td_r, scaled;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [1:0]        rd_idx;
  q_t                reward;

  assign rd_idx = rd_cnt_r[1:0] - 2'd1;
  assign scaled = neg_r ? -q_t'(prod_r[PROD_W-1:FRAC]) : q_t'(prod_r[PROD_W-1:FRAC]);
  assign reward = (div_quot > DVD_W'(Q_HI)) ? Q_HI : q_t'(div_quot);
  assign new_q  = sat_add(cur_r, scaled);

  q_t   best_c;
  logic [1:0] greedy;
  always_comb begin
    best_c = qb_r[0];
    greedy = ACT_DEC;
    if (qb_r[1] > best_c) begin
      best_c = qb_r[1];
      greedy = ACT_HOLD;
    end
    if (qb_r[2] > best_c) begin
      best_c = qb_r[2];
      greedy = ACT_INC;
    end
  end

  // rate scaling: q = rate / 5 by reciprocal, rem = rate - 5q
  logic [63:0] rmul_r;
  logic [29:0] q5;
  logic [31:0] q5x5;
  logic [2:0]  rem5, f4, f6;
  logic [32:0] rq;
  logic [31:0] rate_fin;

  assign q5   = rmul_r[63:34];
  assign q5x5 = {q5, 2'b0} + {2'b0, q5};
  assign rem5 = rate_r[2:0] - q5x5[2:0];

  always_comb begin
    case (rem5)
      3'd0: begin
        f4 = 3'd0;
        f6 = 3'd0;
      end
      3'd1: begin
        f4 = 3'd0;
        f6 = 3'd1;
      end
      3'd2: begin
        f4 = 3'd1;
        f6 = 3'd2;
      end
      3'd3: begin
        f4 = 3'd2;
        f6 = 3'd3;
      end
      default: begin
        f4 = 3'd3;
        f6 = 3'd4;
      end
    endcase
  end

  always_comb begin
    case (act_r)
      ACT_DEC: rq = {1'b0, q5, 2'b0} + {30'b0, f4};
      ACT_INC: rq = {1'b0, q5, 2'b0} + {2'b0, q5, 1'b0} + {30'b0, f6};
      default: rq = {1'b0, rate_r};
    endcase
    if (rq < {1'b0, lr_min_r}) rq = {1'b0, lr_min_r};
    if (rq > {1'b0, lr_max_r}) rq = {1'b0, lr_max_r};
    rate_fin = rq[31:0];
  end

  logic out_valid_r;
  logic [31:0] out_lr_r;
  logic [1:0]  out_act_r;
  logic [BIN_W-1:0] out_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= 1'b0;
      steps_r     <= '0;
      pbin_r      <= '0;
      pact_r      <= ACT_HOLD;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        rd_cnt_r <= '0;
        if (!loaded_r) begin
          loaded_r <= 1'b1;
          rate_r   <= lr_init_r;
        end
      end
      if (cmd.rd_run && rd_cnt_r != 3'd4) rd_cnt_r <= rd_cnt_r + 3'd1;
      if (cmd.fin) begin
        rate_r      <= rate_fin;
        pbin_r      <= bin_r;
        pact_r      <= act_r;
        steps_r     <= steps_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      draw_r <= in_explore_draw;
      rnd_r  <= in_random_action;
      bin_r  <= bin_nxt;
    end
    if (cmd.rd_run && rd_cnt_r != 3'd0) begin
      if (rd_cnt_r == 3'd4) cur_r <= rd_data;
      else qb_r[rd_idx] <= rd_data;
    end
    if (cmd.best) best_r <= best_c;
    if (cmd.mul1) begin
      prod_r <= PROD_W'(q_mag(best_r) * gamma_r);
      neg_r  <= best_r[Q_BITS-1];
    end
    if (cmd.tgt) tgt_r <= sat_add(reward, scaled);
    if (cmd.td) td_r <= sat_sub(tgt_r, cur_r);
    if (cmd.mul2) begin
      prod_r <= PROD_W'(q_mag(td_r) * alpha_r);
      neg_r  <= td_r[Q_BITS-1];
    end
    if (cmd.wr && pbin_r == bin_r) qb_r[pact_r] <= new_q;
    if (cmd.arg) begin
      if (draw_r < explore_r) act_r <= (rnd_r == ACT_BAD) ? ACT_DEC : rnd_r;
      else act_r <= greedy;
    end
    if (cmd.rate_mul) rmul_r <= rate_r * RATE_RECIP;
    if (cmd.fin) begin
      out_lr_r  <= rate_fin;
      out_act_r <= act_r;
      out_bin_r <= bin_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.rd_done  = rd_cnt_r == 3'd4;
  assign sts.out_busy = out_valid_r & ~out_ready;

  assign out_valid         = out_valid_r;
  assign out_learning_rate = out_lr_r;
  assign out_chosen_action = out_act_r;
  assign out_loss_bin      = 6'(out_bin_r);

endmodule

// File: hdl/qlr_ctrl.sv
// Controller: one-hot sequencer stepping the datapath through one beat.
module qlr_ctrl import qlr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qlr_sts_t sts,
  output qlr_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DIV    = 12'b000000000010,
    S_RD     = 12'b000000000100,
    S_BEST   = 12'b000000001000,
    S_MUL1   = 12'b000000010000,
    S_TGT    = 12'b000000100000,
    S_TD     = 12'b000001000000,
    S_MUL2   = 12'b000010000000,
    S_WR     = 12'b000100000000,
    S_ARG    = 12'b001000000000,
    S_RMUL   = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc       = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV:    if (sts.div_done) state_nxt = S_RD;
      S_RD: begin
        cmd.rd_run = 1'b1;
        if (sts.rd_done) state_nxt = S_BEST;
      end
      S_BEST: begin
        cmd.best  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_TD;
      end
      S_TD: begin
        cmd.td    = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_ARG;
      end
      S_ARG: begin
        cmd.arg   = 1'b1;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.rate_mul = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: hdl/qlearning_lr_controller_core.sv
// Top level of the Q-learning learning-rate controller.
// One loss beat in gives one result beat out. The next input beat can be taken
// in the same cycle that the result is presented; a result is held back while the
// previous one still waits on the output. For each beat the 41-step radix-2
// divider forming the reward reciprocal, the table reads, the update sequence
// and a reciprocal multiply for the rate scaling run in turn. Beats are taken
// one at a time; a finished result waits in the output register while the next
// beat is accepted. The Q table clears in the reset cycle through per-entry
// valid bits. Configuration writes are always ready.
module qlearning_lr_controller_core import qlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_loss_value,
  input  logic [15:0] in_explore_draw,
  input  logic [1:0]  in_random_action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_learning_rate,
  output logic [1:0]  out_chosen_action,
  output logic [5:0]  out_loss_bin,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  qlr_cmd_t cmd;
  qlr_sts_t sts;

  assign cfg_ready = 1'b1;

  qlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qlr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_loss_value     (in_loss_value),
    .in_explore_draw   (in_explore_draw),
    .in_random_action  (in_random_action),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_learning_rate (out_learning_rate),
    .out_chosen_action (out_chosen_action),
    .out_loss_bin      (out_loss_bin)
  );

endmodule

// File: hdl/qlr_checker.sv
// Port-level checker for the controller core, bound to the top level.
module qlr_checker import qlr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_learning_rate,
  input logic [1:0]  out_chosen_action,
  input logic [5:0]  out_loss_bin
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_learning_rate)
                                && $stable(out_chosen_action))
    else $error("result beat dropped or changed while stalled");

  a_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chosen_action != ACT_BAD)
    else $error("invalid action code");

  a_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_loss_bin < 6'(NUM_BINS))
    else $error("loss bin out of table");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("new beat taken while one is in work");

endmodule

bind qlearning_lr_controller_core qlr_checker u_chk (.*);
